// ----- hw/rtl/mdc_pkg.sv -----
// Package for the multiply-shift division checker: widths, register indexes, method codes.
package mdc_pkg;

    // Widest operand the block evaluates.
    localparam int MAX_BITS   = 16;
    // Numerator pattern width and quotient width of the ports.
    localparam int NUM_W      = 16;
    localparam int Q_W        = 17;
    // Operand width register, multiplier register, post shift register.
    localparam int NB_W       = 5;
    localparam int MULT_W     = 17;
    localparam int SHIFT_W    = 4;
    // Product of two 18-bit signed operands.
    localparam int OPND_W     = MULT_W + 1;
    localparam int PROD_W     = 2 * OPND_W;
    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    // Restoring divider retires one quotient bit per stage.
    localparam int DIV_STAGES = NUM_W;
    // Stage whose register holds the finished candidate quotient.
    localparam int MAGIC_STAGE = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OPERAND_BITS = 3'd0,
        CFG_IS_SIGNED    = 3'd1,
        CFG_METHOD_CODE  = 3'd2,
        CFG_DIVISOR      = 3'd3,
        CFG_MULTIPLIER   = 3'd4,
        CFG_POST_SHIFT   = 3'd5
    } cfg_idx_t;

    localparam logic [1:0] METHOD_SHIFT = 2'd0;
    localparam logic [1:0] METHOD_HIGH  = 2'd1;
    localparam logic [1:0] METHOD_HALF  = 2'd2;
    localparam logic [1:0] METHOD_RSVD  = 2'd3;

    localparam logic [NB_W-1:0]    RST_OPERAND_BITS = 5'd16;
    localparam logic               RST_IS_SIGNED    = 1'b0;
    localparam logic [1:0]         RST_METHOD_CODE  = METHOD_HIGH;
    localparam logic [NUM_W-1:0]   RST_DIVISOR      = 16'd2;
    localparam logic [MULT_W-1:0]  RST_MULTIPLIER   = 17'd0;
    localparam logic [SHIFT_W-1:0] RST_POST_SHIFT   = 4'd0;

endpackage

// ----- hw/rtl/magic_divide_checker.sv -----
// Top level of the multiply-shift division checker.
//
// Each transfer on the s_ channel carries one numerator; each transfer on the m_ channel
// carries its verdict: the candidate quotient of the configured multiply-shift method, the
// true quotient truncated toward zero, a range-failure flag, a mismatch flag and a pass flag.
// The block takes one numerator per cycle while the output is not stalled and returns
// results in order. The pipeline depth is set by the 16-stage restoring divider
// that forms the true quotient; the candidate path (input decode, 18x18 multiply,
// high-part shift and range check, fix-up, post shift) finishes early and its result
// rides a delay line alongside the divider. The whole pipeline
// advances together: it holds only while a finished result sits in the output register
// and m_ready is low. Configuration registers (index 0 operand_bits, 1 is_signed,
// 2 method_code, 3 divisor, 4 multiplier, 5 post_shift) are written through the cfg_
// channel, which is always ready; writes to other indexes are dropped. Write them only
// while no numerator is in flight, since every stage reads them directly.
module magic_divide_checker
    import mdc_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [NUM_W-1:0]        s_num_pattern,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [Q_W-1:0]   m_magic_quotient,
    output logic signed [Q_W-1:0]   m_exact_quotient,
    output logic                    m_range_fail,
    output logic                    m_mismatch,
    output logic                    m_passes
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [NB_W-1:0]    operand_bits_reg;
    logic               is_signed_reg;
    logic [1:0]         method_code_reg;
    logic [NUM_W-1:0]   divisor_reg;
    logic [MULT_W-1:0]  multiplier_reg;
    logic [SHIFT_W-1:0] post_shift_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            operand_bits_reg <= RST_OPERAND_BITS;
            is_signed_reg    <= RST_IS_SIGNED;
            method_code_reg  <= RST_METHOD_CODE;
            divisor_reg      <= RST_DIVISOR;
            multiplier_reg   <= RST_MULTIPLIER;
            post_shift_reg   <= RST_POST_SHIFT;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_OPERAND_BITS: operand_bits_reg <= cfg_data[NB_W-1:0];
                CFG_IS_SIGNED:    is_signed_reg    <= cfg_data[0];
                CFG_METHOD_CODE:  method_code_reg  <= cfg_data[1:0];
                CFG_DIVISOR:      divisor_reg      <= cfg_data[NUM_W-1:0];
                CFG_MULTIPLIER:   multiplier_reg   <= cfg_data[MULT_W-1:0];
                CFG_POST_SHIFT:   post_shift_reg   <= cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Settings derived from the registers (static while items are in flight)
    // ------------------------------------------------------------------
    logic [NB_W-1:0]          nb_eff;     // operand width clamped to [2, MAX_BITS]
    logic [NUM_W-1:0]         low_mask;
    logic [NUM_W-1:0]         div_eff;    // divisor 0 acts as 1
    logic signed [PROD_W-1:0] half_range; // 2^(N-1)
    logic signed [PROD_W-1:0] range_hi;
    logic signed [PROD_W-1:0] range_lo;
    logic signed [OPND_W-1:0] mult_ext;

    always_comb begin
        if (operand_bits_reg < NB_W'(2)) begin
            nb_eff = NB_W'(2);
        end else if (operand_bits_reg > NB_W'(MAX_BITS)) begin
            nb_eff = NB_W'(MAX_BITS);
        end else begin
            nb_eff = operand_bits_reg;
        end
    end

    assign low_mask   = {NUM_W{1'b1}} >> (NB_W'(NUM_W) - nb_eff);
    assign div_eff    = (divisor_reg == '0) ? NUM_W'(1) : divisor_reg;
    assign half_range = PROD_W'(1) <<< (nb_eff - NB_W'(1));
    assign range_hi   = half_range - PROD_W'(1);
    assign range_lo   = -half_range;
    // Multiplier reads as two's complement only for the signed methods.
    assign mult_ext   = is_signed_reg ? $signed({multiplier_reg[MULT_W-1], multiplier_reg})
                                      : $signed({1'b0, multiplier_reg});

    // ------------------------------------------------------------------
    // Pipeline control: every stage advances together unless the output holds
    // ------------------------------------------------------------------
    logic pipe_en;
    logic v_reg [DIV_STAGES+1];
    logic m_valid_reg;

    assign pipe_en = m_ready || !m_valid_reg;
    assign s_ready = pipe_en;
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= DIV_STAGES; i++) begin
                v_reg[i] <= 1'b0;
            end
            m_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            v_reg[0] <= s_valid;
            for (int i = 1; i <= DIV_STAGES; i++) begin
                v_reg[i] <= v_reg[i-1];
            end
            m_valid_reg <= v_reg[DIV_STAGES];
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: mask and sign-extend the numerator, split off its magnitude
    // ------------------------------------------------------------------
    logic [NUM_W-1:0]       raw_num;
    logic                   num_neg;
    logic signed [Q_W-1:0]  num_val;
    logic [NUM_W-1:0]       num_abs;

    assign raw_num = s_num_pattern & low_mask;
    assign num_neg = is_signed_reg && raw_num[SHIFT_W'(nb_eff - NB_W'(1))];
    assign num_val = $signed(Q_W'(raw_num) - (num_neg ? (Q_W'(1) << nb_eff) : Q_W'(0)));
    assign num_abs = num_neg ? NUM_W'(-num_val) : NUM_W'(num_val);

    // Numerator and its sign travel down the pipe.
    logic signed [Q_W-1:0] nval_reg [3];
    logic [NUM_W-1:0]      nabs_reg;
    logic                  neg_reg  [DIV_STAGES+1];

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            nval_reg[0] <= num_val;
            nval_reg[1] <= nval_reg[0];
            nval_reg[2] <= nval_reg[1];
            nabs_reg    <= num_abs;
            neg_reg[0]  <= num_neg;
            for (int i = 1; i <= DIV_STAGES; i++) begin
                neg_reg[i] <= neg_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // True quotient magnitude: stages 1 to DIV_STAGES
    // ------------------------------------------------------------------
    logic [NUM_W-1:0] quo_abs;

    mdc_div u_div (
        .aclk     (aclk),
        .en       (pipe_en),
        .dividend (nabs_reg),
        .divisor  (div_eff),
        .quotient (quo_abs)
    );

    // ------------------------------------------------------------------
    // Stage 1: full product n * m
    // ------------------------------------------------------------------
    logic signed [OPND_W-1:0] num_opnd;
    logic signed [PROD_W-1:0] prod_reg;

    assign num_opnd = {nval_reg[0][Q_W-1], nval_reg[0]};

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            prod_reg <= num_opnd * mult_ext;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: high part t = floor(n * m / 2^N) and its range check
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] t_full;
    logic                     t_fail;
    logic signed [Q_W-1:0]    t_reg;
    logic                     t_fail_reg;

    assign t_full = prod_reg >>> nb_eff;
    assign t_fail = is_signed_reg ? (t_full < range_lo || t_full > range_hi)
                                  : ($unsigned(t_full) > PROD_W'(low_mask));

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            t_reg      <= t_full[Q_W-1:0];
            t_fail_reg <= t_fail;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: method fix-up step
    // ------------------------------------------------------------------
    logic signed [Q_W:0] fix_val;
    logic                fix_fail;
    logic signed [Q_W:0] t_wide;
    logic signed [Q_W:0] n_wide;
    logic signed [Q_W:0] sum_tn;
    logic signed [Q_W:0] fix_reg;
    logic                fix_fail_reg;

    assign t_wide = {t_reg[Q_W-1], t_reg};
    assign n_wide = {nval_reg[2][Q_W-1], nval_reg[2]};
    assign sum_tn = t_wide + n_wide;

    always_comb begin
        fix_val  = t_wide;
        fix_fail = t_fail_reg;
        if (!is_signed_reg) begin
            case (method_code_reg)
                METHOD_SHIFT: begin
                    // Plain shift of the numerator, no multiply.
                    fix_val  = n_wide;
                    fix_fail = 1'b0;
                end
                METHOD_HIGH: begin
                    fix_val = t_wide;
                end
                default: begin
                    // Add half the difference; t above n cannot be fixed up.
                    if (!t_fail_reg && (t_wide > n_wide)) begin
                        fix_fail = 1'b1;
                    end
                    fix_val = t_wide + ((n_wide - t_wide) >>> 1);
                end
            endcase
        end else if (method_code_reg != METHOD_SHIFT) begin
            // Signed method 1 (codes 2 and 3 alias it): add the numerator back.
            fix_val = sum_tn;
            if (sum_tn < (Q_W+1)'(range_lo) || sum_tn > (Q_W+1)'(range_hi)) begin
                fix_fail = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            fix_reg      <= fix_val;
            fix_fail_reg <= fix_fail;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: post shift, round toward zero for negative numerators
    // ------------------------------------------------------------------
    logic signed [Q_W:0]   shifted;
    logic signed [Q_W-1:0] magic_val;
    logic signed [Q_W-1:0] magic_reg [MAGIC_STAGE:DIV_STAGES];
    logic                  fail_reg  [MAGIC_STAGE:DIV_STAGES];

    assign shifted   = (fix_reg >>> post_shift_reg)
                     + ((is_signed_reg && neg_reg[MAGIC_STAGE-1]) ? (Q_W+1)'(1) : (Q_W+1)'(0));
    assign magic_val = fix_fail_reg ? '0 : shifted[Q_W-1:0];

    // Hold the candidate result until the true quotient catches up.
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            magic_reg[MAGIC_STAGE] <= magic_val;
            fail_reg[MAGIC_STAGE]  <= fix_fail_reg;
            for (int i = MAGIC_STAGE + 1; i <= DIV_STAGES; i++) begin
                magic_reg[i] <= magic_reg[i-1];
                fail_reg[i]  <= fail_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: sign the true quotient and compare
    // ------------------------------------------------------------------
    logic signed [Q_W-1:0] exact_val;
    logic                  quot_equal;
    logic signed [Q_W-1:0] magic_out_reg;
    logic signed [Q_W-1:0] exact_out_reg;
    logic                  fail_out_reg;
    logic                  mismatch_out_reg;
    logic                  passes_out_reg;

    assign exact_val  = neg_reg[DIV_STAGES] ? -$signed({1'b0, quo_abs})
                                            : $signed({1'b0, quo_abs});
    assign quot_equal = (magic_reg[DIV_STAGES] == exact_val);

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            magic_out_reg    <= magic_reg[DIV_STAGES];
            exact_out_reg    <= exact_val;
            fail_out_reg     <= fail_reg[DIV_STAGES];
            mismatch_out_reg <= !fail_reg[DIV_STAGES] && !quot_equal;
            passes_out_reg   <= !fail_reg[DIV_STAGES] && quot_equal;
        end
    end

    assign m_magic_quotient = magic_out_reg;
    assign m_exact_quotient = exact_out_reg;
    assign m_range_fail     = fail_out_reg;
    assign m_mismatch       = mismatch_out_reg;
    assign m_passes         = passes_out_reg;

endmodule

// ----- hw/rtl/mdc_div.sv -----
// Pipelined restoring divider: unsigned quotient, one bit per stage.
module mdc_div
    import mdc_pkg::*;
(
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] dividend,
    input  logic [NUM_W-1:0] divisor,
    output logic [NUM_W-1:0] quotient
);

    // Remainder and the shared dividend/quotient shift word of each stage.
    logic [NUM_W-1:0] rem_reg [DIV_STAGES];
    logic [NUM_W-1:0] nq_reg  [DIV_STAGES];

    for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
        logic [NUM_W-1:0] rem_in;
        logic [NUM_W-1:0] nq_in;
        logic [NUM_W:0]   trial;
        logic             fits;
        logic [NUM_W-1:0] rem_next;
        logic [NUM_W-1:0] nq_next;

        if (i == 0) begin : g_first
            assign rem_in = '0;
            assign nq_in  = dividend;
        end else begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign nq_in  = nq_reg[i-1];
        end

        // Bring down the next dividend bit and try the subtract.
        assign trial    = {rem_in, nq_in[NUM_W-1]};
        assign fits     = trial >= {1'b0, divisor};
        assign rem_next = fits ? NUM_W'(trial - {1'b0, divisor}) : trial[NUM_W-1:0];
        assign nq_next  = {nq_in[NUM_W-2:0], fits};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i] <= rem_next;
                nq_reg[i]  <= nq_next;
            end
        end
    end

    assign quotient = nq_reg[DIV_STAGES-1];

endmodule
